[hw/rtl/sbch_pkg.sv]
`timescale 1ns / 1ps
// Package for the segment/box closest-hit block: stream widths, register map,
// face codes, controller/datapath command and status structs, helpers.
package sbch_pkg;

    localparam int IN_W   = 216;   // 209 field bits padded to whole bytes
    localparam int OUT_W  = 184;   // 179 field bits padded to whole bytes
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_FROM_X = 3'd0;
    localparam logic [2:0] REG_FROM_Y = 3'd1;
    localparam logic [2:0] REG_FROM_Z = 3'd2;
    localparam logic [2:0] REG_TO_X   = 3'd3;
    localparam logic [2:0] REG_TO_Y   = 3'd4;
    localparam logic [2:0] REG_TO_Z   = 3'd5;
    localparam logic [2:0] REG_INSIDE = 3'd6;

    localparam logic [2:0] FACE_MISS   = 3'd0;
    localparam logic [2:0] FACE_INSIDE = 3'd6;

    typedef struct packed {
        logic       load;
        logic       next_axis;
        logic       div_init;
        logic       div_step;
        logic       mul_lerp;
        logic       lerp_wr;
        logic       set_hit;
        logic       set_inside;
        logic       mul_dist;
        logic       acc;
        logic       finish;
        logic [1:0] sel;        // lerp lane (0: b, 1: c) or distance axis
    } cmd_t;

    typedef struct packed {
        logic below;
        logic above;
        logic early;
        logic in_b;
        logic in_c;
        logic start_in;
        logic last_axis;
        logic out_free;
    } sts_t;

    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        diff33 = {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = v[32] ? -v : v;
        mag33 = n[31:0];
    endfunction

endpackage

[hw/rtl/segment_box_closest_hit.sv]
`timescale 1ns / 1ps
// Segment against axis-aligned box, closest-hit tracking: top level.
// Depends on sbch_pkg, sbch_ctrl, sbch_dp.
//
// One box at a time. From accept to result an item steps through EVAL for each
// axis in turn (an early miss goes straight to FINAL). For each face that is
// cut, the shared one-bit-per-cycle divider forms the 32-bit crossing fraction,
// then two multiply/add/check lanes (MUL, LERP, CHK) run; a hit then adds the
// squared distance (DMUL and DACC for each axis), and FINAL waits while the output
// register is still held by m_tready. The next item is taken once the result
// sits in the output register. The segment and the inside mode come from the APB
// registers at 4*i.
module segment_box_closest_hit import sbch_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [31:0] box_min_x, [63:32] box_min_y, [95:64] box_min_z, [127:96] box_max_x,
    // [159:128] box_max_y, [191:160] box_max_z, [207:192] box_tag, [208] new_query
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] hit, [1] closer, [33:2] point_x, [65:34] point_y, [97:66] point_z,
    // [100:98] face, [162:101] dist_sqr, [178:163] tag_out
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [2:0][31:0] from_reg, to_reg;
    logic             inside_reg;
    logic [2:0]       ridx;
    cmd_t             cmd;
    sts_t             sts;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_reg   <= '0;
            to_reg     <= '0;
            inside_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_FROM_X: from_reg[0] <= pwdata;
                REG_FROM_Y: from_reg[1] <= pwdata;
                REG_FROM_Z: from_reg[2] <= pwdata;
                REG_TO_X:   to_reg[0]   <= pwdata;
                REG_TO_Y:   to_reg[1]   <= pwdata;
                REG_TO_Z:   to_reg[2]   <= pwdata;
                REG_INSIDE: inside_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_FROM_X: prdata = from_reg[0];
            REG_FROM_Y: prdata = from_reg[1];
            REG_FROM_Z: prdata = from_reg[2];
            REG_TO_X:   prdata = to_reg[0];
            REG_TO_Y:   prdata = to_reg[1];
            REG_TO_Z:   prdata = to_reg[2];
            REG_INSIDE: prdata = {31'd0, inside_reg};
            default:    prdata = '0;
        endcase
    end

    sbch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbch_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .p1_i      (from_reg),
        .p2_i      (to_reg),
        .inside_en (inside_reg),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // closer only ever accompanies a hit
    a_closer_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
        else $error("closer without hit");

    // a miss carries zero point, face and distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[162:2] == '0))
        else $error("miss with nonzero payload");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

endmodule

[hw/rtl/sbch_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the segment/box closest-hit block.
// Depends on sbch_pkg; drives sbch_dp through cmd_t, reads sts_t.
module sbch_ctrl import sbch_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EVAL   = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_MULB   = 4'd3;
    localparam logic [3:0] ST_LERPB  = 4'd4;
    localparam logic [3:0] ST_CHKB   = 4'd5;
    localparam logic [3:0] ST_MULC   = 4'd6;
    localparam logic [3:0] ST_LERPC  = 4'd7;
    localparam logic [3:0] ST_CHKC   = 4'd8;
    localparam logic [3:0] ST_INSIDE = 4'd9;
    localparam logic [3:0] ST_DMUL   = 4'd10;
    localparam logic [3:0] ST_DACC   = 4'd11;
    localparam logic [3:0] ST_FINAL  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.early) begin
                    state_next = ST_FINAL;
                end else if (sts.below || sts.above) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end else if (sts.last_axis) begin
                    state_next = ST_INSIDE;
                end else begin
                    cmd.next_axis = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 5'd31) state_next = ST_MULB;
                else                  cnt_next   = cnt_reg + 5'd1;
            end
            ST_MULB: begin
                cmd.mul_lerp = 1'b1;
                state_next   = ST_LERPB;
            end
            ST_LERPB: begin
                cmd.lerp_wr = 1'b1;
                state_next  = ST_CHKB;
            end
            ST_CHKB: begin
                if (sts.in_b) begin
                    state_next = ST_MULC;
                end else if (sts.last_axis) begin
                    state_next = ST_INSIDE;
                end else begin
                    cmd.next_axis = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_MULC: begin
                cmd.mul_lerp = 1'b1;
                cmd.sel      = 2'd1;
                state_next   = ST_LERPC;
            end
            ST_LERPC: begin
                cmd.lerp_wr = 1'b1;
                cmd.sel     = 2'd1;
                state_next  = ST_CHKC;
            end
            ST_CHKC: begin
                if (sts.in_c) begin
                    cmd.set_hit = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_DMUL;
                end else if (sts.last_axis) begin
                    state_next = ST_INSIDE;
                end else begin
                    cmd.next_axis = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_INSIDE: begin
                if (sts.start_in) begin
                    cmd.set_inside = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_DMUL;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_DMUL: begin
                cmd.mul_dist = 1'b1;
                cmd.sel      = cnt_reg[1:0];
                state_next   = ST_DACC;
            end
            ST_DACC: begin
                cmd.acc = 1'b1;
                if (cnt_reg == 5'd2) begin
                    state_next = ST_FINAL;
                end else begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_DMUL;
                end
            end
            ST_FINAL: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/sbch_dp.sv]
`timescale 1ns / 1ps
// Datapath: box registers, shared restoring divider, shared 32x32 multiplier,
// crossing checks, distance accumulator, best-hit state and output register.
// Depends on sbch_pkg.
module sbch_dp import sbch_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [2:0][31:0]  p1_i,
    input  logic [2:0][31:0]  p2_i,
    input  logic              inside_en,
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    logic [2:0][31:0] mn_reg, mx_reg, pt_reg;
    logic [1:0][31:0] crd_reg;
    logic [15:0]      tag_reg;
    logic [1:0]       axis_reg;
    logic [31:0]      plane_reg;
    logic [2:0]       fc_reg, face_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      den_reg, q_reg;
    logic [63:0]      prod_reg;
    logic             hit_reg;
    logic [61:0]      acc_reg;
    logic             have_best_reg, have_best_next;
    logic [61:0]      best_reg, best_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg;

    logic [1:0]         a, bx, cx, lx;
    logic signed [31:0] p1a, p2a, mna, mxa, plane_w, p1l, p2l, cb, cc, crd_w;
    logic signed [32:0] dl, lerp_sum;
    logic [31:0]        num_w, den_w, mul_a, mul_b, off, dk;
    logic               below, above, in_all;
    logic               div_ge;
    logic [32:0]        div_r;
    logic               closer_w;

    assign a   = axis_reg;
    assign bx  = (a == 2'd0) ? 2'd1 : 2'd0;
    assign cx  = (a == 2'd2) ? 2'd1 : 2'd2;
    assign p1a = $signed(p1_i[a]);
    assign p2a = $signed(p2_i[a]);
    assign mna = $signed(mn_reg[a]);
    assign mxa = $signed(mx_reg[a]);

    assign below   = p1a < mna;
    assign above   = p1a > mxa;
    assign plane_w = below ? mna : mxa;
    assign num_w   = mag33(diff33(plane_w, p1a));
    assign den_w   = mag33(diff33(p2a, p1a));

    // lerp lane: other axis b or c of the current cut
    assign lx  = cmd.sel[0] ? cx : bx;
    assign p1l = $signed(p1_i[lx]);
    assign p2l = $signed(p2_i[lx]);
    assign dl  = diff33(p2l, p1l);
    assign off = prod_reg[62:31];
    assign lerp_sum = dl[32] ? ({p1l[31], p1l} - {1'b0, off})
                             : ({p1l[31], p1l} + {1'b0, off});
    assign crd_w = lerp_sum[31:0];

    assign dk    = mag33(diff33($signed(pt_reg[cmd.sel]), $signed(p1_i[cmd.sel])));
    assign mul_a = cmd.mul_dist ? dk : mag33(dl);
    assign mul_b = cmd.mul_dist ? dk : q_reg;

    assign div_ge = rem_reg >= {1'b0, den_reg};
    assign div_r  = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    assign cb = $signed(crd_reg[0]);
    assign cc = $signed(crd_reg[1]);

    always_comb begin
        in_all = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (!($signed(mn_reg[k]) <= $signed(p1_i[k]) &&
                  $signed(p1_i[k]) <= $signed(mx_reg[k])))
                in_all = 1'b0;
        end
    end

    always_comb begin
        sts.below     = below;
        sts.above     = above;
        sts.early     = below ? (p2a < mna) : (above && (p2a > mxa));
        sts.in_b      = (cb > $signed(mn_reg[bx])) && (cb < $signed(mx_reg[bx]));
        sts.in_c      = (cc > $signed(mn_reg[cx])) && (cc < $signed(mx_reg[cx]));
        sts.start_in  = in_all && inside_en;
        sts.last_axis = (a == 2'd2);
        sts.out_free  = !m_valid_reg || m_tready;
    end

    assign closer_w = hit_reg && (!have_best_reg || (acc_reg < best_reg));

    always_comb begin
        have_best_next = have_best_reg;
        best_next      = best_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        if (cmd.load && s_tdata[208]) have_best_next = 1'b0;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
            if (closer_w) begin
                have_best_next = 1'b1;
                best_next      = acc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            best_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            have_best_reg <= have_best_next;
            best_reg      <= best_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                mn_reg[k] <= s_tdata[32*k +: 32];
                mx_reg[k] <= s_tdata[96 + 32*k +: 32];
            end
            tag_reg  <= s_tdata[207:192];
            axis_reg <= 2'd0;
            pt_reg   <= '0;
            face_reg <= FACE_MISS;
            hit_reg  <= 1'b0;
            acc_reg  <= '0;
        end
        if (cmd.next_axis) axis_reg <= axis_reg + 2'd1;
        if (cmd.div_init) begin
            plane_reg <= plane_w;
            fc_reg    <= {a, !below};
            den_reg   <= den_w;
            rem_reg   <= (num_w > den_w) ? {1'b0, den_w} : {1'b0, num_w};
            q_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= {div_r[31:0], 1'b0};
            q_reg   <= {q_reg[30:0], div_ge};
        end
        if (cmd.mul_lerp || cmd.mul_dist) prod_reg <= mul_a * mul_b;
        if (cmd.lerp_wr) crd_reg[cmd.sel[0]] <= crd_w;
        if (cmd.set_hit) begin
            for (int j = 0; j < 3; j++) begin
                if (j == int'(a))       pt_reg[j] <= plane_reg;
                else if (j == int'(bx)) pt_reg[j] <= crd_reg[0];
                else                    pt_reg[j] <= crd_reg[1];
            end
            face_reg <= fc_reg;
            hit_reg  <= 1'b1;
        end
        if (cmd.set_inside) begin
            pt_reg   <= p1_i;
            face_reg <= FACE_INSIDE;
            hit_reg  <= 1'b1;
        end
        // three 48-bit terms never overflow the 62-bit accumulator
        if (cmd.acc) acc_reg <= acc_reg + {14'd0, prod_reg[63:16]};
        if (cmd.finish) begin
            m_data_reg <= {5'd0, tag_reg, acc_reg, face_reg,
                           pt_reg[2], pt_reg[1], pt_reg[0], closer_w, hit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
